/* sv/ple_pkg.sv */
package ple_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;

    typedef enum logic [1:0] {
        KIND_INS_FRONT = 2'd0,
        KIND_INS_POS   = 2'd1,
        KIND_DELETE    = 2'd2,
        KIND_SEARCH    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

endpackage

/* sv/ple_store.sv */
module ple_store
    import ple_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/positional_list_engine.sv */
// Ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel: i_valid / o_stall carries a command (kind, value, position).
// Output channel: o_valid / i_stall carries one result per command: status,
// removed value, 1-based match position and the entry count afterwards.
// One command is worked at a time; o_stall is high from acceptance until the
// result is loaded into the output register.
// All entries live in a single-port-write, registered-read memory, and every
// shift or compare goes through that read port, one entry at a time (S_READ, then S_APPLY):
//   rejected command or empty search: straight to S_DONE
//   insert at slot s:    entries s..count-1 move up by one, then S_PUT writes s
//   delete at slot p:    entry p is captured, later entries move down by one
//   search:              entries compared from the first until a match or the end
// A new command may be accepted in the cycle after the result is loaded.
// While the receiver stalls, the result holds in the output register and a
// finished command waits in S_DONE before the block takes the next one.
// Synchronous reset empties the list and drops any pending result; no
// clearing pass is needed since only entries below the count are read.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]          i_position,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_status,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic [POS_W-1:0]          o_found_position,
    output logic [POS_W-1:0]          o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_APPLY = 5'b00100,
        S_PUT   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    t_kind                     r_kind, n_kind;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_slot, n_slot;
    logic [CW-1:0]             r_count, n_count;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic signed [VALUE_W-1:0] r_removed, n_removed;
    logic [CW-1:0]             r_found, n_found;
    t_status                   r_status, n_status;

    logic                      r_out_valid;
    logic [2:0]                r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [POS_W-1:0]          r_out_found;
    logic [POS_W-1:0]          r_out_count;

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic [AW-1:0]             w_raddr;
    logic signed [VALUE_W-1:0] w_rdata;

    logic [31:0]               w_cnt32;
    logic [31:0]               w_pos32;
    logic [CW-1:0]             w_pos_m1;
    logic [CW-1:0]             w_idx_dec;
    logic [CW-1:0]             w_idx_inc;
    logic                      w_full;
    logic                      w_bad_ins;
    logic                      w_bad_del;
    logic                      w_out_free;
    logic                      w_is_ins;

    ple_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cnt32    = {{(32-CW){1'b0}}, r_count};
    assign w_pos32    = {{(32-POS_W){1'b0}}, i_position};
    assign w_pos_m1   = CW'(w_pos32 - 32'd1);
    assign w_idx_dec  = r_idx - CW'(1);
    assign w_idx_inc  = r_idx + CW'(1);
    assign w_full     = (w_cnt32 == 32'(CAPACITY));
    assign w_bad_ins  = (i_position == '0) || (w_pos32 > w_cnt32 + 32'd1);
    assign w_bad_del  = (i_position == '0) || (w_pos32 > w_cnt32);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_is_ins   = (r_kind == KIND_INS_FRONT) || (r_kind == KIND_INS_POS);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_count   = r_count;
        n_value   = r_value;
        n_removed = r_removed;
        n_found   = r_found;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = r_idx[AW-1:0];
        w_wdata   = w_rdata;
        w_raddr   = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind    = t_kind'(i_kind);
                    n_value   = i_value;
                    n_removed = '0;
                    n_found   = '0;
                    n_status  = ST_OK;
                    n_state   = S_DONE;
                    case (t_kind'(i_kind))
                        KIND_INS_FRONT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_slot  = '0;
                                n_idx   = r_count;
                                n_state = (r_count != '0) ? S_READ : S_PUT;
                            end
                        end
                        KIND_INS_POS: begin
                            if (w_bad_ins) begin
                                n_status = ST_BADPOS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_slot  = w_pos_m1;
                                n_idx   = r_count;
                                n_state = (r_count != w_pos_m1) ? S_READ : S_PUT;
                            end
                        end
                        KIND_DELETE: begin
                            if (w_bad_del) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_slot  = w_pos_m1;
                                n_idx   = w_pos_m1;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                w_raddr = w_is_ins ? w_idx_dec[AW-1:0] : r_idx[AW-1:0];
                n_state = S_APPLY;
            end
            S_APPLY: begin
                case (r_kind) inside
                    KIND_INS_FRONT, KIND_INS_POS: begin
                        w_we    = 1'b1;
                        w_waddr = r_idx[AW-1:0];
                        n_idx   = w_idx_dec;
                        n_state = (w_idx_dec != r_slot) ? S_READ : S_PUT;
                    end
                    KIND_DELETE: begin
                        if (r_idx == r_slot) begin
                            n_removed = w_rdata;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_idx_dec[AW-1:0];
                        end
                        n_idx = w_idx_inc;
                        if (w_idx_inc < r_count) begin
                            n_state = S_READ;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        if (w_rdata == r_value) begin
                            n_found = w_idx_inc;
                            n_state = S_DONE;
                        end else if (w_idx_inc == r_count) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = w_idx_inc;
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_slot[AW-1:0];
                w_wdata = r_value;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_value   <= n_value;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_status  <= n_status;
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_status;
            r_out_value  <= r_removed;
            r_out_found  <= POS_W'({{(32-CW){1'b0}}, r_found});
            r_out_count  <= POS_W'(w_cnt32);
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_value   = r_out_value;
    assign o_found_position = r_out_found;
    assign o_entry_count    = r_out_count;

endmodule

/* sim/ple_list_checker.sv */
module ple_list_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  logic                      i_cmd_stall,
    input  logic [1:0]                i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]          i_position,
    input  logic                      i_rsp_valid,
    input  logic                      i_rsp_stall,
    input  logic [2:0]                i_status,
    input  logic signed [VALUE_W-1:0] i_result_value,
    input  logic [POS_W-1:0]          i_found_position,
    input  logic [POS_W-1:0]          i_entry_count,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_list_len
);

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] removed;
        logic [POS_W-1:0]          found;
        logic [POS_W-1:0]          count;
    } t_list_result;

    logic signed [VALUE_W-1:0] list_mem [CAPACITY];
    int                        list_len     = 0;
    int                        fail_count   = 0;
    int                        pending      = 0;
    t_list_result              expected_results [$];

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_list_len   = list_len;

    function automatic t_status insert_entry(int slot, logic signed [VALUE_W-1:0] v);
        if (list_len >= CAPACITY) begin
            return ST_FULL;
        end
        for (int i = list_len; i > slot; i--) begin
            list_mem[i] = list_mem[i - 1];
        end
        list_mem[slot] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic t_list_result apply_command(t_kind k, logic signed [VALUE_W-1:0] v,
                                                   logic [POS_W-1:0] p);
        t_list_result r;
        int           pos;
        pos       = int'(p);
        r.status  = ST_OK;
        r.removed = '0;
        r.found   = '0;
        case (k)
            KIND_INS_FRONT: begin
                r.status = insert_entry(0, v);
            end
            KIND_INS_POS: begin
                if (pos < 1 || pos > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.status = insert_entry(pos - 1, v);
                end
            end
            KIND_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.removed = list_mem[pos - 1];
                    for (int i = pos - 1; i + 1 < list_len; i++) begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_len--;
                end
            end
            default: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < list_len; i++) begin
                        if (r.status == ST_NOTFOUND && list_mem[i] == v) begin
                            r.status = ST_OK;
                            r.found  = POS_W'(i + 1);
                        end
                    end
                end
            end
        endcase
        r.count = POS_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_cmd_valid && !i_cmd_stall) begin
                expected_results.push_back(apply_command(t_kind'(i_kind), i_value, i_position));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                got.status  = t_status'(i_status);
                got.removed = i_result_value;
                got.found   = i_found_position;
                got.count   = i_entry_count;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result: status %0d removed %0d found %0d count %0d",
                                 i_status, i_result_value, i_found_position, i_entry_count);
                    end
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("mismatch (expected/actual): status %0d/%0d removed %0d/%0d",
                                     want.status, i_status, want.removed, i_result_value);
                            $display("    found %0d/%0d count %0d/%0d",
                                     want.found, i_found_position, want.count, i_entry_count);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

/* sim/positional_list_engine_tb.sv */
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int CAPACITY = 16;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_valid    = 1'b0;
    logic [1:0]                i_kind     = '0;
    logic signed [VALUE_W-1:0] i_value    = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic                      i_stall    = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic [2:0]                o_status;
    logic signed [VALUE_W-1:0] o_result_value;
    logic [POS_W-1:0]          o_found_position;
    logic [POS_W-1:0]          o_entry_count;

    int fail_count;
    int pending;
    int list_len;

    bit src_idle   = 1'b1;
    bit rcv_idle   = 1'b1;
    int hold_reqs  = 0;
    int hold_done  = 0;
    int hold_left  = 0;

    always #6 i_clk = ~i_clk;

    positional_list_engine #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_result_value   (o_result_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    ple_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_stall      (o_stall),
        .i_kind           (i_kind),
        .i_value          (i_value),
        .i_position       (i_position),
        .i_rsp_valid      (o_valid),
        .i_rsp_stall      (i_stall),
        .i_status         (o_status),
        .i_result_value   (o_result_value),
        .i_found_position (o_found_position),
        .i_entry_count    (o_entry_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_list_len       (list_len)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_reqs) begin
            i_stall   <= 1'b1;
            hold_done <= hold_done + 1;
            hold_left <= 300;
        end else begin
            i_stall <= rcv_idle && ($urandom_range(0, 99) < 30);
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic wait_slot();
        @(negedge i_clk);
        while (src_idle && $urandom_range(0, 99) < 30) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic offer(t_kind k, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        i_valid    <= 1'b1;
        i_kind     <= k;
        i_value    <= v;
        i_position <= p;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(t_kind k, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        wait_slot();
        offer(k, v, p);
    endtask

    initial begin
        logic signed [VALUE_W-1:0] recent [8];
        int                        recent_idx;
        bit                        fill_mode;
        foreach (recent[i]) begin
            recent[i] = '0;
        end
        recent_idx = 0;
        fill_mode  = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(KIND_SEARCH, 5, 5'd0);
        send_cmd(KIND_DELETE, 0, 5'd1);
        send_cmd(KIND_DELETE, 0, 5'd0);
        send_cmd(KIND_INS_POS, 7, 5'd0);
        send_cmd(KIND_INS_POS, 7, 5'd2);
        send_cmd(KIND_INS_POS, VAL_MIN, 5'd1);
        send_cmd(KIND_INS_FRONT, VAL_MAX, 5'd31);
        send_cmd(KIND_INS_POS, 0, 5'd3);
        send_cmd(KIND_INS_POS, -1, 5'd2);
        send_cmd(KIND_INS_POS, 9, 5'd31);
        send_cmd(KIND_SEARCH, VAL_MIN, 5'd0);
        send_cmd(KIND_SEARCH, 12345, 5'd31);
        send_cmd(KIND_INS_FRONT, -1, 5'd0);
        send_cmd(KIND_SEARCH, -1, 5'd0);
        send_cmd(KIND_DELETE, 0, 5'd5);
        send_cmd(KIND_DELETE, 0, 5'd5);
        send_cmd(KIND_DELETE, 0, 5'd2);
        send_cmd(KIND_DELETE, 0, 5'd31);
        for (int n = 4; n <= CAPACITY; n++) begin
            send_cmd(KIND_INS_POS, $urandom, POS_W'(n));
        end
        send_cmd(KIND_INS_FRONT, 1, 5'd0);
        send_cmd(KIND_INS_POS, 2, POS_W'(CAPACITY + 1));
        send_cmd(KIND_INS_POS, 3, POS_W'(CAPACITY + 2));
        send_cmd(KIND_INS_POS, 4, 5'd0);
        send_cmd(KIND_DELETE, 0, POS_W'(CAPACITY));
        send_cmd(KIND_DELETE, 0, 5'd1);

        src_idle = 1'b0;
        rcv_idle = 1'b0;
        for (int n = 0; n < 1900; n++) begin
            t_kind                     k;
            logic signed [VALUE_W-1:0] v;
            logic [POS_W-1:0]          p;
            int                        r;
            int                        cnt;
            if (n == 500) begin
                src_idle = 1'b1;
                rcv_idle = 1'b1;
            end
            if (n == 1200) begin
                hold_reqs++;
            end
            if (n % 150 == 0) begin
                fill_mode = !fill_mode;
            end
            wait_slot();
            cnt = list_len;
            r   = $urandom_range(0, 99);
            if (fill_mode) begin
                k = r < 30 ? KIND_INS_FRONT : r < 60 ? KIND_INS_POS :
                    r < 75 ? KIND_DELETE : KIND_SEARCH;
            end else begin
                k = r < 10 ? KIND_INS_FRONT : r < 25 ? KIND_INS_POS :
                    r < 65 ? KIND_DELETE : KIND_SEARCH;
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                v = $urandom;
            end else if (r < 70) begin
                v = int'($urandom_range(0, 6)) - 3;
            end else if (r < 80) begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end else begin
                v = recent[$urandom_range(0, 7)];
            end
            if (k == KIND_SEARCH && $urandom_range(0, 1) == 1) begin
                v = recent[$urandom_range(0, 7)];
            end
            if (k == KIND_INS_POS && $urandom_range(0, 99) < 85) begin
                p = POS_W'($urandom_range(1, cnt + 1));
            end else if (k == KIND_DELETE && cnt > 0 && $urandom_range(0, 99) < 85) begin
                p = POS_W'($urandom_range(1, cnt));
            end else begin
                p = POS_W'($urandom_range(0, 31));
            end
            if (k == KIND_INS_FRONT || k == KIND_INS_POS) begin
                recent[recent_idx] = v;
                recent_idx = (recent_idx + 1) % 8;
            end
            offer(k, v, p);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* positional_list_engine.f */
sv/ple_pkg.sv
sv/ple_store.sv
sv/positional_list_engine.sv
sim/ple_list_checker.sv
sim/positional_list_engine_tb.sv
